// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl files, included by the top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// ===== hdl/bsag_pkg.sv =====
// shared constants, register index codes and structs of the 3-d block scatter address generator
// no dependencies
package bsag_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int DIM_BITS       = 21;
   localparam int ADDR_BITS      = 48;

   localparam int BLK_BITS       = 40;
   localparam int STRIDE_BITS    = 40;
   localparam int POS_BITS       = 6;
   localparam int OFS_BITS       = 2;
   // blocks per axis: ceil(size / 4) needs one bit less than the size
   localparam int DIV_BITS       = DIM_BITS - 1;
   localparam int LO_BITS        = ADDR_BITS / 2;
   localparam int HI_BITS        = ADDR_BITS - LO_BITS;
   localparam int CSR_BITS       = (ADDR_BITS > STRIDE_BITS) ? ADDR_BITS : STRIDE_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int AXES           = 3;
   // input register loads at the accept edge, then two dividers of one stage per
   // quotient bit and five tail stages
   localparam int LATENCY        = 2 * BLK_BITS + 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SIZE_X       = 3'd0,
      CSR_SIZE_Y       = 3'd1,
      CSR_SIZE_Z       = 3'd2,
      CSR_STRIDE_X     = 3'd3,
      CSR_STRIDE_Y     = 3'd4,
      CSR_STRIDE_Z     = 3'd5,
      CSR_BASE_ADDRESS = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]  size_x;
      logic [DIM_BITS-1:0]  size_y;
      logic [DIM_BITS-1:0]  size_z;
      logic [DIV_BITS-1:0]  blocks_x;
      logic [DIV_BITS-1:0]  blocks_y;
      logic [ADDR_BITS-1:0] step_x;
      logic [ADDR_BITS-1:0] step_y;
      logic [ADDR_BITS-1:0] step_z;
      logic [ADDR_BITS-1:0] base_address;
   } cfg_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   element_position;
      logic [VALUE_BITS-1:0] sample_value;
      logic [DIV_BITS-1:0]   rem_x;
   } side_type;

endpackage

// ===== hdl/bsag_cfg.sv =====
// configuration registers and the values derived from them (blocks per axis, strides)
// depends on bsag_pkg
module bsag_cfg import bsag_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]       csr_write_data,
   output cfg_type                   cfg
);

   logic [DIM_BITS-1:0]    size_x_ff, size_y_ff, size_z_ff;
   logic [DIM_BITS-1:0]    size_x_in, size_y_in, size_z_in;
   logic [STRIDE_BITS-1:0] stride_x_ff, stride_y_ff, stride_z_ff;
   logic [STRIDE_BITS-1:0] stride_x_in, stride_y_in, stride_z_in;
   logic [ADDR_BITS-1:0]   base_ff, base_in;

   logic [2*DIM_BITS-1:0]  area_ff, area_in;
   logic [DIM_BITS:0]      size_x_p3, size_y_p3;
   logic [DIV_BITS-1:0]    blocks_x_ff, blocks_y_ff;
   logic [ADDR_BITS-1:0]   step_x_ff, step_y_ff, step_z_ff;
   logic [ADDR_BITS-1:0]   step_x_in, step_y_in, step_z_in;

   always_comb begin
      size_x_in   = size_x_ff;
      size_y_in   = size_y_ff;
      size_z_in   = size_z_ff;
      stride_x_in = stride_x_ff;
      stride_y_in = stride_y_ff;
      stride_z_in = stride_z_ff;
      base_in     = base_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SIZE_X:       size_x_in   = csr_write_data[DIM_BITS-1:0];
            CSR_SIZE_Y:       size_y_in   = csr_write_data[DIM_BITS-1:0];
            CSR_SIZE_Z:       size_z_in   = csr_write_data[DIM_BITS-1:0];
            CSR_STRIDE_X:     stride_x_in = csr_write_data[STRIDE_BITS-1:0];
            CSR_STRIDE_Y:     stride_y_in = csr_write_data[STRIDE_BITS-1:0];
            CSR_STRIDE_Z:     stride_z_in = csr_write_data[STRIDE_BITS-1:0];
            CSR_BASE_ADDRESS: base_in     = csr_write_data[ADDR_BITS-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= DIM_BITS'(1);
         size_y_ff   <= DIM_BITS'(1);
         size_z_ff   <= DIM_BITS'(1);
         stride_x_ff <= '0;
         stride_y_ff <= '0;
         stride_z_ff <= '0;
         base_ff     <= '0;
      end else begin
         size_x_ff   <= size_x_in;
         size_y_ff   <= size_y_in;
         size_z_ff   <= size_z_in;
         stride_x_ff <= stride_x_in;
         stride_y_ff <= stride_y_in;
         stride_z_ff <= stride_z_in;
         base_ff     <= base_in;
      end
   end

   // derived values are registered from the config registers; the dense z step
   // also passes through the registered area product
   assign size_x_p3 = {1'b0, size_x_ff} + (DIM_BITS+1)'(3);
   assign size_y_p3 = {1'b0, size_y_ff} + (DIM_BITS+1)'(3);
   assign area_in   = size_x_ff * size_y_ff;

   // zero stride picks the dense layout
   assign step_x_in = (stride_x_ff != '0) ? ADDR_BITS'(stride_x_ff) : ADDR_BITS'(1);
   assign step_y_in = (stride_y_ff != '0) ? ADDR_BITS'(stride_y_ff) : ADDR_BITS'(size_x_ff);
   assign step_z_in = (stride_z_ff != '0) ? ADDR_BITS'(stride_z_ff) : ADDR_BITS'(area_ff);

   always_ff @(posedge clock) begin
      area_ff     <= area_in;
      blocks_x_ff <= size_x_p3[DIM_BITS:OFS_BITS];
      blocks_y_ff <= size_y_p3[DIM_BITS:OFS_BITS];
      step_x_ff   <= step_x_in;
      step_y_ff   <= step_y_in;
      step_z_ff   <= step_z_in;
   end

   assign cfg.size_x       = size_x_ff;
   assign cfg.size_y       = size_y_ff;
   assign cfg.size_z       = size_z_ff;
   assign cfg.blocks_x     = blocks_x_ff;
   assign cfg.blocks_y     = blocks_y_ff;
   assign cfg.step_x       = step_x_ff;
   assign cfg.step_y       = step_y_ff;
   assign cfg.step_z       = step_z_ff;
   assign cfg.base_address = base_ff;

endmodule

// ===== hdl/bsag_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with a sideband that travels along
// depends on bsag_pkg
module bsag_div import bsag_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [BLK_BITS-1:0] in_dividend,
   input  logic [DIV_BITS-1:0] divisor,
   input  side_type            in_side,
   output logic                out_valid,
   output logic [BLK_BITS-1:0] out_quotient,
   output logic [DIV_BITS-1:0] out_remainder,
   output side_type            out_side
);

   logic                valid_ff [BLK_BITS];
   logic                valid_in [BLK_BITS];
   logic [DIV_BITS-1:0] rem_ff   [BLK_BITS];
   logic [DIV_BITS-1:0] rem_in   [BLK_BITS];
   // unconsumed dividend bits shift out the top, quotient bits shift in below
   logic [BLK_BITS-1:0] work_ff  [BLK_BITS];
   logic [BLK_BITS-1:0] work_in  [BLK_BITS];
   side_type            side_ff  [BLK_BITS];
   side_type            side_in  [BLK_BITS];

   for (genvar i = 0; i < BLK_BITS; i++) begin : g_step
      logic                src_valid;
      logic [DIV_BITS-1:0] src_rem;
      logic [BLK_BITS-1:0] src_work;
      side_type            src_side;
      logic [DIV_BITS:0]   trial;
      logic [DIV_BITS:0]   diff;
      logic                fits;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = '0;
         assign src_work  = in_dividend;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_work  = work_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      assign trial      = {src_rem, src_work[BLK_BITS-1]};
      assign diff       = trial - {1'b0, divisor};
      assign fits       = (trial >= {1'b0, divisor});
      assign valid_in[i] = src_valid;
      assign rem_in[i]   = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      assign work_in[i]  = {src_work[BLK_BITS-2:0], fits};
      assign side_in[i]  = src_side;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BLK_BITS; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BLK_BITS; i++) begin
         rem_ff[i]  <= rem_in[i];
         work_ff[i] <= work_in[i];
         side_ff[i] <= side_in[i];
      end
   end

   assign out_valid     = valid_ff[BLK_BITS-1];
   assign out_quotient  = work_ff[BLK_BITS-1];
   assign out_remainder = rem_ff[BLK_BITS-1];
   assign out_side      = side_ff[BLK_BITS-1];

endmodule

// ===== hdl/bsag_addr.sv =====
// element coordinates, field bounds check and strided address sum, five register stages
// depends on bsag_pkg
module bsag_addr import bsag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   input  logic [BLK_BITS-1:0]   in_block_z,
   input  logic [DIV_BITS-1:0]   in_rem_y,
   input  side_type              in_side,
   output logic                  rsp_valid,
   output logic [ADDR_BITS-1:0]  rsp_write_address,
   output logic [VALUE_BITS-1:0] rsp_write_value
);

   // bounds check
   logic [OFS_BITS-1:0]   ofs_x, ofs_y, ofs_z;
   logic [DIM_BITS:0]     gx_full, gy_full;
   logic [DIM_BITS+1:0]   gz_full;
   logic                  sizes_ok, in_field;

   logic                  c_valid_ff, c_valid_in;
   logic [DIM_BITS-1:0]   coord_ff [AXES];
   logic [DIM_BITS-1:0]   coord_in [AXES];
   logic [VALUE_BITS-1:0] c_value_ff;

   // partial products
   logic [ADDR_BITS-1:0]        step       [AXES];
   logic [DIM_BITS+LO_BITS-1:0] prod_lo_in [AXES];
   logic [DIM_BITS+LO_BITS-1:0] prod_lo_ff [AXES];
   logic [DIM_BITS+HI_BITS-1:0] prod_hi_in [AXES];
   logic [HI_BITS-1:0]          prod_hi_ff [AXES];
   logic                        d_valid_ff;
   logic [VALUE_BITS-1:0]       d_value_ff;

   // per-axis offsets
   logic [ADDR_BITS-1:0]  part_in [AXES];
   logic [ADDR_BITS-1:0]  part_ff [AXES];
   logic                  e_valid_ff;
   logic [VALUE_BITS-1:0] e_value_ff;

   // two partial sums
   logic [ADDR_BITS-1:0]  sum_a_ff, sum_b_ff;
   logic                  f_valid_ff;
   logic [VALUE_BITS-1:0] f_value_ff;

   logic                  out_valid_ff;
   logic [ADDR_BITS-1:0]  out_address_ff;
   logic [VALUE_BITS-1:0] out_value_ff;

   assign ofs_x   = in_side.element_position[OFS_BITS-1:0];
   assign ofs_y   = in_side.element_position[2*OFS_BITS-1:OFS_BITS];
   assign ofs_z   = in_side.element_position[3*OFS_BITS-1:2*OFS_BITS];
   assign gx_full = {in_side.rem_x, ofs_x};
   assign gy_full = {in_rem_y, ofs_y};
   assign gz_full = {in_block_z[DIM_BITS-1:0], ofs_z};

   // a zero size leaves the dividers with garbage, so it must drop the item here
   assign sizes_ok = (cfg.size_x != '0) && (cfg.size_y != '0) && (cfg.size_z != '0);
   assign in_field = sizes_ok
                     && (in_block_z < BLK_BITS'(cfg.size_z))
                     && (gx_full < (DIM_BITS+1)'(cfg.size_x))
                     && (gy_full < (DIM_BITS+1)'(cfg.size_y))
                     && (gz_full < (DIM_BITS+2)'(cfg.size_z));

   assign c_valid_in  = in_valid && in_field;
   assign coord_in[0] = gx_full[DIM_BITS-1:0];
   assign coord_in[1] = gy_full[DIM_BITS-1:0];
   assign coord_in[2] = gz_full[DIM_BITS-1:0];

   assign step[0] = cfg.step_x;
   assign step[1] = cfg.step_y;
   assign step[2] = cfg.step_z;

   // stride split in two halves keeps each multiplier narrow; only the low
   // bits of the upper product reach the address
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         prod_lo_in[k] = coord_ff[k] * step[k][LO_BITS-1:0];
         prod_hi_in[k] = coord_ff[k] * step[k][ADDR_BITS-1:LO_BITS];
         part_in[k]    = ADDR_BITS'(prod_lo_ff[k]) + {prod_hi_ff[k], LO_BITS'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         d_valid_ff   <= c_valid_ff;
         e_valid_ff   <= d_valid_ff;
         f_valid_ff   <= e_valid_ff;
         out_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < AXES; k++) begin
         coord_ff[k]   <= coord_in[k];
         prod_lo_ff[k] <= prod_lo_in[k];
         prod_hi_ff[k] <= prod_hi_in[k][HI_BITS-1:0];
         part_ff[k]    <= part_in[k];
      end
      c_value_ff     <= in_side.sample_value;
      d_value_ff     <= c_value_ff;
      e_value_ff     <= d_value_ff;
      sum_a_ff       <= part_ff[0] + part_ff[1];
      sum_b_ff       <= part_ff[2] + cfg.base_address;
      f_value_ff     <= e_value_ff;
      out_address_ff <= sum_a_ff + sum_b_ff;
      out_value_ff   <= f_value_ff;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_address = out_address_ff;
   assign rsp_write_value   = out_value_ff;

endmodule

// ===== hdl/block_scatter_address_gen_3d.sv =====
// top level of the 3-d block scatter address generator: input register, two dividers, address tail
// depends on bsag_pkg, bsag_cfg, bsag_div, bsag_addr and assert_macros.svh
//
// each start transfer brings one decoded value of a 4x4x4 block: linear block
// index, element position inside the block and the sample bits. the block
// index is split into block coordinates (x fastest, then y, z the rest) and,
// if the element lies inside the field, one write of address and value comes
// out on the rsp_ ports, marked by rsp_valid for exactly one cycle.
// busy stays low: a new item may start in every cycle, one item per cycle.
// the strobe follows the start transfer (for every kept item) through the input
// register, the two dividers, one quotient bit per stage over the 40-bit block
// index, and the address tail. dropped items leave a gap and never reorder the stream.
// the receiver cannot hold results off, so nothing is ever stalled.
// csr_ writes show on the config registers in the next cycle; the user must
// make them only while no item is in flight, the block does not enforce it.
// reset clears all stage valid bits and returns sizes to one, strides and base to zero.
`include "assert_macros.svh"

module block_scatter_address_gen_3d import bsag_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [BLK_BITS-1:0]       req_block_index,
   input  logic [POS_BITS-1:0]       req_element_position,
   input  logic [VALUE_BITS-1:0]     req_sample_value,
   output logic                      rsp_valid,
   output logic [ADDR_BITS-1:0]      rsp_write_address,
   output logic [VALUE_BITS-1:0]     rsp_write_value,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]       csr_write_data
);

   cfg_type               cfg;

   logic                  req_valid_ff;
   logic [BLK_BITS-1:0]   blk_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [VALUE_BITS-1:0] value_ff;
   side_type              side0;

   logic                  d1_valid;
   logic [BLK_BITS-1:0]   d1_quotient;
   logic [DIV_BITS-1:0]   d1_remainder;
   side_type              d1_side;
   side_type              side1;

   logic                  d2_valid;
   logic [BLK_BITS-1:0]   d2_quotient;
   logic [DIV_BITS-1:0]   d2_remainder;
   side_type              d2_side;

   assign busy = 1'b0;

   bsag_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff   <= req_block_index;
      pos_ff   <= req_element_position;
      value_ff <= req_sample_value;
   end

   assign side0.element_position = pos_ff;
   assign side0.sample_value     = value_ff;
   assign side0.rem_x            = '0;

   // block index / blocks_x: remainder is the x block, quotient goes on
   bsag_div u_div_x (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid_ff),
      .in_dividend   (blk_ff),
      .divisor       (cfg.blocks_x),
      .in_side       (side0),
      .out_valid     (d1_valid),
      .out_quotient  (d1_quotient),
      .out_remainder (d1_remainder),
      .out_side      (d1_side)
   );

   assign side1.element_position = d1_side.element_position;
   assign side1.sample_value     = d1_side.sample_value;
   assign side1.rem_x            = d1_remainder;

   // rest / blocks_y: remainder is the y block, quotient the z block
   bsag_div u_div_y (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d1_valid),
      .in_dividend   (d1_quotient),
      .divisor       (cfg.blocks_y),
      .in_side       (side1),
      .out_valid     (d2_valid),
      .out_quotient  (d2_quotient),
      .out_remainder (d2_remainder),
      .out_side      (d2_side)
   );

   bsag_addr u_addr (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (d2_valid),
      .in_block_z        (d2_quotient),
      .in_rem_y          (d2_remainder),
      .in_side           (d2_side),
      .rsp_valid         (rsp_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_value   (rsp_write_value)
   );

   // every result goes back to a start transfer a fixed latency earlier
   `ASSERT_IMPLY(a_rsp_has_start, clock, reset, rsp_valid, $past(start && !busy, LATENCY + 1))
   // the value rides along the pipeline without slipping a stage
   `ASSERT_IMPLY(a_rsp_value_aligned, clock, reset, rsp_valid, rsp_write_value == $past(req_sample_value, LATENCY + 1))
   // the x divider leaves a remainder below its divisor
   `ASSERT_IMPLY(a_div_x_remainder, clock, reset, d1_valid && (cfg.blocks_x != '0), d1_remainder < cfg.blocks_x)
   // a size write shows on the config bundle in the next cycle
   `ASSERT_NEXT(a_size_x_write, clock, reset, csr_write_enable && (csr_index == CSR_SIZE_X), cfg.size_x == $past(csr_write_data[DIM_BITS-1:0]))

endmodule
